@@ sv/jmn_pkg.sv @@
// jmn_pkg: shared types, action codes and constants for the joystick menu navigator
// no dependencies; imported by every module of the block
package jmn_pkg;

  localparam int unsigned NumScreens = 4;  // last screen index, home is 1
  localparam int unsigned LuxScreen  = 2;  // screen whose click clears the lux average

  localparam int unsigned CfgAddrW   = 4;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_LEFT  = 3'd1,
    ACT_RIGHT = 3'd2,
    ACT_UP    = 3'd3,
    ACT_DOWN  = 3'd4,
    ACT_CLICK = 3'd5,
    ACT_LONG  = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    REG_LONG_PRESS = 2'd0,
    REG_HIGH_THR   = 2'd1,
    REG_LOW_THR    = 2'd2,
    REG_TIMEOUT    = 2'd3
  } reg_idx_t;

  localparam logic [3:0]  ScreenOff      = 4'd0;
  localparam logic [3:0]  ScreenHome     = 4'd1;
  localparam logic [3:0]  ScreenLast     = 4'(NumScreens);
  localparam logic [3:0]  ScreenLux      = 4'(LuxScreen);

  localparam logic [15:0] LongPressReset = 16'd100;
  localparam logic [11:0] HighThrReset   = 12'd3000;
  localparam logic [11:0] LowThrReset    = 12'd1000;
  localparam logic [15:0] TimeoutReset   = 16'd3000;

  typedef struct packed {
    logic [15:0] long_press_samples;
    logic [11:0] high_threshold;
    logic [11:0] low_threshold;
    logic [15:0] screen_timeout_samples;
  } cfg_t;

  typedef struct packed {
    logic        button_down;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
  } sample_t;

  typedef struct packed {
    action_t     action;
    logic [3:0]  screen;
    logic        home_mode;
    logic        clear_average;
    logic        redraw;
  } result_t;

  function automatic logic [15:0] sat_inc16(input logic [15:0] v);
    return (v == 16'hFFFF) ? 16'hFFFF : v + 16'd1;
  endfunction

endpackage

@@ sv/jmn_if.sv @@
// jmn_in_if / jmn_out_if: valid-ready channels for samples and results
// no dependencies; the action code is carried as a plain 3-bit field
interface jmn_in_if;
  logic        valid;
  logic        ready;
  logic        button_down;
  logic [11:0] pos_x;
  logic [11:0] pos_y;

  modport source (output valid, output button_down, output pos_x, output pos_y,
                  input ready);
  modport sink   (input valid, input button_down, input pos_x, input pos_y,
                  output ready);
endinterface

interface jmn_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [3:0]  screen;
  logic        home_mode;
  logic        clear_average;
  logic        redraw;

  modport source (output valid, output action, output screen, output home_mode,
                  output clear_average, output redraw, input ready);
  modport sink   (input valid, input action, input screen, input home_mode,
                  input clear_average, input redraw, output ready);
endinterface

@@ sv/jmn_cfg_regs.sv @@
// jmn_cfg_regs: apb-style register file holding thresholds and sample limits
// depends on jmn_pkg for cfg_t and register indexes
module jmn_cfg_regs
  import jmn_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output cfg_t                cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press_samples     <= LongPressReset;
      cfg_r.high_threshold         <= HighThrReset;
      cfg_r.low_threshold          <= LowThrReset;
      cfg_r.screen_timeout_samples <= TimeoutReset;
    end else if (wr_en) begin
      unique case (idx)
        REG_LONG_PRESS: cfg_r.long_press_samples     <= pwdata[15:0];
        REG_HIGH_THR:   cfg_r.high_threshold         <= pwdata[11:0];
        REG_LOW_THR:    cfg_r.low_threshold          <= pwdata[11:0];
        REG_TIMEOUT:    cfg_r.screen_timeout_samples <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_LONG_PRESS: prdata = {16'd0, cfg_r.long_press_samples};
      REG_HIGH_THR:   prdata = {20'd0, cfg_r.high_threshold};
      REG_LOW_THR:    prdata = {20'd0, cfg_r.low_threshold};
      REG_TIMEOUT:    prdata = {16'd0, cfg_r.screen_timeout_samples};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

@@ sv/jmn_nav.sv @@
// jmn_nav: press/stick decoding, screen selector and timeout state
// depends on jmn_pkg; state advances only when en is high
module jmn_nav
  import jmn_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    en,
  input  sample_t smp,
  input  cfg_t    cfg,
  output result_t res
);

  logic        press_active_r, press_active_nxt;
  logic [15:0] press_count_r, press_count_nxt;
  logic        stick_moved_r, stick_moved_nxt;
  logic [15:0] idle_count_r, idle_count_nxt;
  logic [3:0]  screen_r, screen_nxt;
  logic        home_r, home_nxt;
  action_t     act;
  logic        clr;
  logic        y_hi, y_lo, x_hi, x_lo, neutral;

  assign y_hi    = smp.pos_y > cfg.high_threshold;
  assign y_lo    = smp.pos_y < cfg.low_threshold;
  assign x_hi    = smp.pos_x > cfg.high_threshold;
  assign x_lo    = smp.pos_x < cfg.low_threshold;
  assign neutral = (smp.pos_x < cfg.high_threshold) && (smp.pos_x > cfg.low_threshold) &&
                   (smp.pos_y < cfg.high_threshold) && (smp.pos_y > cfg.low_threshold);

  always_comb begin
    act              = ACT_NONE;
    clr              = 1'b0;
    press_count_nxt  = press_count_r;
    press_active_nxt = press_active_r;
    stick_moved_nxt  = stick_moved_r;
    idle_count_nxt   = idle_count_r;
    screen_nxt       = screen_r;
    home_nxt         = home_r;

    // button: release gives a click unless the screen is off, hold past the limit a long click and re-arm
    if (smp.button_down) begin
      press_count_nxt  = press_active_r ? sat_inc16(press_count_r) : 16'd0;
      press_active_nxt = 1'b1;
      if (press_count_nxt > cfg.long_press_samples) begin
        act              = ACT_LONG;
        press_active_nxt = 1'b0;
      end
    end else begin
      if (press_active_r && (screen_r != ScreenOff)) act = ACT_CLICK;
      press_active_nxt = 1'b0;
    end

    // stick only read with no press held; fires once then latches
    if (!press_active_nxt) begin
      if (!stick_moved_r && (y_hi || y_lo || x_hi || x_lo)) begin
        stick_moved_nxt = 1'b1;
        if (y_hi)      act = ACT_LEFT;
        else if (y_lo) act = ACT_RIGHT;
        else if (x_hi) act = ACT_DOWN;
        else           act = ACT_UP;
      end else if (neutral) begin
        stick_moved_nxt = 1'b0;
      end
    end

    if (act == ACT_NONE) begin
      idle_count_nxt = sat_inc16(idle_count_r);
      if (idle_count_nxt > cfg.screen_timeout_samples) screen_nxt = ScreenOff;
    end else begin
      idle_count_nxt = 16'd0;
      if (screen_r == ScreenOff) begin
        screen_nxt = ScreenHome;
      end else begin
        case (act)
          ACT_RIGHT: screen_nxt = (screen_r >= ScreenLast) ? ScreenHome : screen_r + 4'd1;
          ACT_LEFT:  screen_nxt = (screen_r <= ScreenHome) ? ScreenLast : screen_r - 4'd1;
          ACT_CLICK: begin
            if (screen_r == ScreenHome)     home_nxt = ~home_r;
            else if (screen_r == ScreenLux) clr      = 1'b1;
          end
          ACT_LONG:  screen_nxt = ScreenOff;
          default:   screen_nxt = ScreenHome;
        endcase
      end
    end

    res.action        = act;
    res.screen        = screen_nxt;
    res.home_mode     = home_nxt;
    res.clear_average = clr;
    res.redraw        = (act != ACT_NONE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_active_r <= 1'b0;
      press_count_r  <= 16'd0;
      stick_moved_r  <= 1'b0;
      idle_count_r   <= 16'd0;
      screen_r       <= ScreenHome;
      home_r         <= 1'b0;
    end else if (en) begin
      press_active_r <= press_active_nxt;
      press_count_r  <= press_count_nxt;
      stick_moved_r  <= stick_moved_nxt;
      idle_count_r   <= idle_count_nxt;
      screen_r       <= screen_nxt;
      home_r         <= home_nxt;
    end
  end

endmodule

@@ sv/joystick_menu_navigator.sv @@
// path: a sample transaction loads the input reg, then the result reg once that stage is free
// throughput: one sample per cycle while out_chan.ready takes results; jmn_nav next-state logic is combinational
// a sample is taken into an empty input stage even while a finished result waits on out_chan.ready
// reset: synchronous active-low rst_n; screen home, home mode, counters and latches cleared
// config registers reset to long press 100, thresholds 3000/1000, timeout 3000
// top level: input stage, navigator state, result stage; uses jmn_pkg, jmn_if, submodules
module joystick_menu_navigator
  import jmn_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  jmn_in_if.sink              in_chan,
  jmn_out_if.source           out_chan,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [CfgAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  cfg_t    cfg;
  sample_t smp_r;
  logic    in_vld_r;
  result_t res;
  result_t out_r;
  logic    out_vld_r, out_vld_nxt;
  logic    adv;

  // register file for thresholds and limits
  jmn_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a held sample moves to the result stage when that stage is empty or drains now
  assign adv           = in_vld_r && (!out_vld_r || out_chan.ready);
  assign in_chan.ready = !in_vld_r || adv;

  // input stage: valid is control, payload only loads on a transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_vld_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      smp_r.button_down <= in_chan.button_down;
      smp_r.pos_x       <= in_chan.pos_x;
      smp_r.pos_y       <= in_chan.pos_y;
    end
  end

  // navigator state commits in the same cycle the result is captured
  jmn_nav u_nav (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .smp   (smp_r),
    .cfg   (cfg),
    .res   (res)
  );

  // result stage
  always_comb begin
    if (adv)                 out_vld_nxt = 1'b1;
    else if (out_chan.ready) out_vld_nxt = 1'b0;
    else                     out_vld_nxt = out_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_chan.valid         = out_vld_r;
  assign out_chan.action        = out_r.action;
  assign out_chan.screen        = out_r.screen;
  assign out_chan.home_mode     = out_r.home_mode;
  assign out_chan.clear_average = out_r.clear_average;
  assign out_chan.redraw        = out_r.redraw;

endmodule

@@ sv/jmn_checker.sv @@
// jmn_checker: port-level assertions on the result channel of the navigator
// depends on jmn_pkg; bound to joystick_menu_navigator below
module jmn_checker
  import jmn_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] action,
  input logic [3:0] screen,
  input logic       clear_average,
  input logic       redraw
);

  // redraw flags exactly the results that carry an action
  a_redraw: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (redraw == (action != ACT_NONE)))
    else $error("redraw does not match action");

  // a clear request only comes from a click on the lux screen
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && clear_average) |-> (action == ACT_CLICK && screen == ScreenLux))
    else $error("clear_average without click on lux screen");

  // long click always ends with the screen off or waking to home
  a_long: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && action == ACT_LONG) |-> (screen == ScreenOff || screen == ScreenHome))
    else $error("long click left an unexpected screen");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (screen <= ScreenLast))
    else $error("screen beyond last");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(action) && $stable(screen)))
    else $error("stalled result changed");

endmodule

bind joystick_menu_navigator jmn_checker u_jmn_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .action        (out_chan.action),
  .screen        (out_chan.screen),
  .clear_average (out_chan.clear_average),
  .redraw        (out_chan.redraw)
);
